// ===== rtl/pcm_downmix_resampler_top_assert.svh =====
// Assertion macros for the PCM downmix resampler.
// Used by modules that clock on clk and reset on rst_n (active low).
`ifndef PCM_DOWNMIX_RESAMPLER_TOP_ASSERT_SVH
`define PCM_DOWNMIX_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PDR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define PDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdr_pkg.sv =====
// Shared types and constants for the PCM downmix resampler.
// No dependencies; imported by pdr_downmix and pcm_downmix_resampler_top.
`default_nettype none

package pdr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 8;
  localparam int PHASE_W  = 22;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 2'd2;

  // Q16 phase constants
  localparam logic [PHASE_W-1:0] ONE_Q16    = 22'h01_0000;
  localparam logic [PHASE_W-1:0] MIN_STEP   = 22'h00_1000;
  localparam logic [PHASE_W-1:0] STEP_RESET = 22'h01_0000;

  // Sample format selection handed to the downmixer
  typedef struct packed {
    logic sixteen_bit;
    logic stereo;
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/pdr_downmix.sv =====
// Downmix of one left/right frame to an 8-bit unsigned sample.
// Depends on pdr_pkg (mode_t, widths).
`default_nettype none

module pdr_downmix (
  input  pdr_pkg::mode_t                   mode,
  input  logic [pdr_pkg::SAMPLE_W-1:0]     left_sample,
  input  logic [pdr_pkg::SAMPLE_W-1:0]     right_sample,
  output logic [pdr_pkg::OUT_W-1:0]        sample_out
);
  import pdr_pkg::*;

  logic [SAMPLE_W-1:0] right_sel;
  logic [SAMPLE_W:0]   sum16;
  logic [OUT_W:0]      sum8;

  // Mono reuses the left channel
  assign right_sel = mode.stereo ? right_sample : left_sample;

  // 16-bit: flip sign bits to offset binary, average, keep top byte
  assign sum16 = {1'b0, left_sample ^ 16'h8000} + {1'b0, right_sel ^ 16'h8000};
  // 8-bit: average the low bytes
  assign sum8  = {1'b0, left_sample[OUT_W-1:0]} + {1'b0, right_sel[OUT_W-1:0]};

  // Both averages already fit in 0..255, no clamp needed
  assign sample_out = mode.sixteen_bit ? sum16[SAMPLE_W:SAMPLE_W-OUT_W+1]
                                       : sum8[OUT_W:1];

endmodule

`default_nettype wire

// ===== rtl/pcm_downmix_resampler_top.sv =====
// PCM downmix with nearest-neighbor Q16 resampling, top level.
// Depends on pdr_pkg, pdr_downmix and pcm_downmix_resampler_top_assert.svh.
//
// Usage:
//   Input stream carries one source frame per transfer (left, right samples).
//   Output stream carries one 8-bit sample per transfer; tlast marks the final
//   result caused by a frame. A frame may cause 0 to 16 results depending on
//   the phase accumulator and the step register; a dropped frame gives none.
//   Configuration is a plain write port (enable, index, data), to be written
//   only while the block is idle; the block itself does not enforce this.
//   A step below 4096 is stored as 4096. The first result of a frame passes
//   through the frame register, then the output register.
//   Throughput: one frame per cycle while out_tready stays high and each frame
//   gives one result or none; a frame giving several results holds the result
//   generator until its last one, one result per output transfer, and the next
//   frame is taken in the cycle that produces the last result. The single frame
//   register and the output register set this rate.
//   Reset: accumulator cleared, registers to 16-bit stereo with unity step,
//   no frame pending, output empty.
//   Stall: when out_tready is low the output register holds its result; the
//   frame register still takes one frame while no frame is pending.
`default_nettype none

module pcm_downmix_resampler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [15:0] left_sample, [31:16] right_sample
  // Output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] sample_out
  output logic                              out_tlast,  // last_of_run
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdr_pkg::PHASE_W-1:0]       cfg_wdata
);
  import pdr_pkg::*;

  // Configuration registers
  mode_t               mode_r;
  logic [PHASE_W-1:0]  step_r;

  // Phase and frame state
  logic [PHASE_W-1:0]  acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic [SAMPLE_W-1:0] left_r, right_r;

  // Output register
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic                out_last_r;

  logic                gen_fire, gen_last, in_fire, drop;
  logic [PHASE_W:0]    phase_sum;
  logic [PHASE_W:0]    phase_wrap;
  logic [PHASE_W-1:0]  acc_after, acc_cur;
  logic [OUT_W-1:0]    mix_sample;

  // Configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r.sixteen_bit <= 1'b1;
      mode_r.stereo      <= 1'b1;
      step_r             <= STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SIXTEEN_BIT: mode_r.sixteen_bit <= cfg_wdata[0];
        CFG_STEREO:      mode_r.stereo      <= cfg_wdata[0];
        CFG_STEP:        step_r <= (cfg_wdata < MIN_STEP) ? MIN_STEP : cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Downmix of the held frame
  pdr_downmix u_downmix (
    .mode         (mode_r),
    .left_sample  (left_r),
    .right_sample (right_r),
    .sample_out   (mix_sample)
  );

  // Result generation: one result per free output slot while a frame is held
  assign gen_fire   = pend_r && (!out_valid_r || out_tready);
  assign phase_sum  = {1'b0, acc_r} + {1'b0, step_r};
  assign gen_last   = |phase_sum[PHASE_W:16];
  assign phase_wrap = phase_sum - {1'b0, ONE_Q16};
  assign acc_after  = gen_last ? phase_wrap[PHASE_W-1:0] : phase_sum[PHASE_W-1:0];

  // New frame accepted when none is held, or as the held one finishes
  assign in_tready = !pend_r || (gen_fire && gen_last);
  assign in_fire   = in_tvalid && in_tready;
  assign acc_cur   = gen_fire ? acc_after : acc_r;
  assign drop      = |acc_cur[PHASE_W-1:16];

  always_comb begin
    acc_nxt  = acc_cur;
    pend_nxt = pend_r;
    if (gen_fire && gen_last) begin
      pend_nxt = 1'b0;
    end
    if (in_fire) begin
      if (drop) begin
        acc_nxt = acc_cur - ONE_Q16;
      end else begin
        pend_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      if (gen_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire && !drop) begin
      left_r  <= in_tdata[15:0];
      right_r <= in_tdata[31:16];
    end
    if (gen_fire) begin
      out_data_r <= mix_sample;
      out_last_r <= gen_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  `include "pcm_downmix_resampler_top_assert.svh"

  `PDR_ASSERT_IMPLY(a_ready_when_free, !pend_r, in_tready, "input stalled with no frame held")
  `PDR_ASSERT_NEXT(a_last_frees, gen_fire && gen_last && !in_fire, !pend_r, "frame held past last")
  `PDR_ASSERT_NEXT(a_mid_run_phase, gen_fire && !gen_last, acc_r < ONE_Q16, "phase wrapped mid run")
  `PDR_ASSERT_IMPLY(a_rise_has_src, $rose(out_tvalid), $past(pend_r), "result without held frame")

endmodule

`default_nettype wire

// ===== dv/tb_pcm_downmix_resampler_top.sv =====
// Self-checking testbench for pcm_downmix_resampler_top: downmix, 8-bit conversion and
// Q16 nearest-neighbor resampling, checked transfer by transfer against an in-bench predictor.
// Depends on pdr_pkg and the RTL under rtl/; reads no files.

module tb_pcm_downmix_resampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RUNS_PER_CFG = 6;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // One sample in Q16, at the predictor's phase width
  localparam logic [PHASE_W:0] ONE_WIDE = {1'b0, ONE_Q16};

  typedef struct packed {
    logic [OUT_W-1:0] sample;
    logic             last;
  } mix_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;    // [15:0] left_sample, [31:16] right_sample
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;        // [7:0] sample_out
  logic                 out_tlast;        // last_of_run
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PHASE_W-1:0]   cfg_wdata = '0;

  // Predictor state and register mirror
  mix_result_t          expected_mix_q[$];
  logic                 mode_sixteen = 1'b1;
  logic                 mode_stereo = 1'b1;
  logic [PHASE_W-1:0]   mode_step = STEP_RESET;
  logic [PHASE_W:0]     phase_acc = '0;
  int unsigned          frames_sent = 0;

  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          hold_cycles = 0;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;

  pcm_downmix_resampler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Output checker: each transfer against the oldest expected result
  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_mix_q.size() == 0) begin
        report_mismatch("unexpected output sample", int'(out_tdata), -1);
      end else begin
        want = expected_mix_q.pop_front();
        if (out_tdata !== want.sample)
          report_mismatch("sample_out", int'(out_tdata), int'(want.sample));
        if (out_tlast !== want.last)
          report_mismatch("last_of_run", int'(out_tlast), int'(want.last));
      end
    end
  end

  // Predict the results of one accepted frame and advance the phase
  task automatic predict_frame(input logic [15:0] left, input logic [15:0] right);
    logic [15:0]      partner;
    logic [16:0]      sum;
    logic [OUT_W-1:0] mixed;
    logic [PHASE_W:0] eff_step;
    mix_result_t      res;
    partner  = mode_stereo ? right : left;
    eff_step = {1'b0, ((mode_step < MIN_STEP) ? MIN_STEP : mode_step)};
    // Frame dropped while the phase is a whole sample or more ahead
    if (phase_acc >= ONE_WIDE) begin
      phase_acc = phase_acc - ONE_WIDE;
      return;
    end
    if (mode_sixteen) begin
      // offset binary, floor average, then keep the top byte
      sum   = {1'b0, left ^ 16'h8000} + {1'b0, partner ^ 16'h8000};
      mixed = sum[16:9];
    end else begin
      sum   = {9'd0, left[7:0]} + {9'd0, partner[7:0]};
      mixed = sum[8:1];
    end
    res.sample = mixed;
    do begin
      phase_acc = phase_acc + eff_step;
      res.last  = (phase_acc >= ONE_WIDE);
      expected_mix_q.push_back(res);
    end while (!res.last);
    phase_acc = phase_acc - ONE_WIDE;
    phase_acc[PHASE_W] = 1'b0;
  endtask

  // One input transfer, with random idle cycles ahead of it
  task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    do @(posedge clk); while (!in_tready);
    predict_frame(left, right);
    frames_sent++;
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] corners[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
    if ($urandom_range(0, 7) == 0)
      return corners[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  // Register write; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SIXTEEN_BIT: mode_sixteen = value[0];
      CFG_STEREO:      mode_stereo = value[0];
      CFG_STEP:        mode_step = value;
      default: ;
    endcase
  endtask

  // Stop offering, wait for every expected result, then let dropped frames finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_mix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Send frames until the phase is back under one sample
  task automatic flush_phase();
    while (phase_acc >= ONE_WIDE) send_frame(pick_sample(), pick_sample());
  endtask

  // Reset values: 16-bit stereo, unity step, signed extremes
  task automatic test_default_format();
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h0000, 16'h0000);
    send_frame(16'hFFFF, 16'h0000);
    settle();
  endtask

  // Mono repeats left; 8-bit mode ignores the high bytes
  task automatic test_mono_and_8bit();
    write_reg(CFG_STEREO, 22'd0);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    settle();
    write_reg(CFG_SIXTEEN_BIT, 22'd0);
    send_frame(16'hAB01, 16'h00FF);
    send_frame(16'h00FF, 16'h0000);
    settle();
    write_reg(CFG_STEREO, 22'd1);
    send_frame(16'h12FF, 16'hAB00);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'hFF00, 16'h0000);
    send_frame(16'h5A80, 16'hA581);
    settle();
    write_reg(CFG_SIXTEEN_BIT, 22'd1);
  endtask

  // Step clamping, unknown index, heavy decimation with dropped frames
  task automatic test_step_limits();
    write_reg(CFG_STEP, 22'd0);
    send_frame(16'h1234, 16'hEDCB);
    send_frame(16'h8000, 16'h8001);
    settle();
    write_reg(CFG_STEP, 22'd4095);
    send_frame(16'h7FFF, 16'h0000);
    settle();
    write_reg(CFG_UNUSED, 22'h3F_FFFF);
    send_frame(16'h4000, 16'hC000);
    settle();
    write_reg(CFG_STEP, MIN_STEP);
    send_frame(16'h0100, 16'h0300);
    settle();
    write_reg(CFG_STEP, 22'h3F_FFFF);
    send_frame(16'h8000, 16'h0000);
    send_frame(16'h7FFF, 16'h0000);
    flush_phase();
    settle();
  endtask

  // Random formats, steps and samples under each idling mix
  task automatic test_random_traffic();
    int unsigned target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int k = 0; k < 4; k++) begin
        settle();
        write_reg(CFG_SIXTEEN_BIT, PHASE_W'($urandom_range(0, 1)));
        write_reg(CFG_STEREO, PHASE_W'($urandom_range(0, 1)));
        case ($urandom_range(0, 9))
          0: write_reg(CFG_STEP, PHASE_W'($urandom_range(0, 4095)));
          1: write_reg(CFG_STEP, PHASE_W'($urandom_range(2097152, 4194303)));
          2: write_reg(CFG_STEP, MIN_STEP);
          default: write_reg(CFG_STEP, PHASE_W'($urandom_range(4096, 196608)));
        endcase
        target = frames_sent + RUNS_PER_CFG;
        while (frames_sent < target) send_frame(pick_sample(), pick_sample());
      end
    end
    settle();
  endtask

  // Receiver holds off while frames keep coming, so the input stalls
  task automatic test_output_holdoff();
    write_reg(CFG_SIXTEEN_BIT, 22'd1);
    write_reg(CFG_STEREO, 22'd1);
    write_reg(CFG_STEP, 22'd16384);
    flush_phase();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    for (int i = 0; i < 24; i++) send_frame(pick_sample(), pick_sample());
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_format();
    test_mono_and_8bit();
    test_step_limits();
    test_random_traffic();
    test_output_holdoff();
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
